// ===== src/tdfa_pkg.sv =====
// shared types and constants for the travel direction frame aligner
package tdfa_pkg;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [15:0] zx;
    logic signed [15:0] zy;
    logic signed [15:0] zz;
    logic               seg_end;
  } wp_t;

  // job kinds handed from the front to the back
  localparam logic [1:0] JOB_PAIR   = 2'd0;  // held waypoint then new one
  localparam logic [1:0] JOB_SINGLE = 2'd1;  // lone last waypoint, zero axes

  typedef struct packed {
    logic [1:0]         kind;
    logic               two;      // also emit the last waypoint
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [33:0] dz;
    logic signed [15:0] hzx;
    logic signed [15:0] hzy;
    logic signed [15:0] hzz;
    logic signed [15:0] nzx;
    logic signed [15:0] nzy;
    logic signed [15:0] nzz;
  } job_t;

  function automatic logic signed [15:0] rsat14(input logic signed [35:0] v);
    logic signed [35:0] t;
    logic signed [21:0] q;
    begin
      t = v + 36'sd8192;
      q = t[35:14];
      if (q > 22'sd32767) rsat14 = 16'sh7fff;
      else if (q < -22'sd32768) rsat14 = 16'sh8000;
      else rsat14 = q[15:0];
    end
  endfunction

endpackage

// ===== src/tdfa_front.sv =====
// front end: holds waypoints and forms step jobs
module tdfa_front import tdfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  wp_t  wp,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);
  logic               held_valid;
  logic signed [31:0] hx, hy, hz;
  logic signed [15:0] tzx, tzy, tzz;
  logic               acc;

  assign in_ready = job_ready;
  assign acc = in_valid && in_ready;
  assign job_valid = in_valid && (held_valid || wp.seg_end);

  always_comb begin
    job.kind = held_valid ? JOB_PAIR : JOB_SINGLE;
    job.two  = wp.seg_end;
    job.dx   = 34'(wp.px) - 34'(hx);
    job.dy   = 34'(wp.py) - 34'(hy);
    job.dz   = 34'(wp.pz) - 34'(hz);
    job.hzx  = tzx;
    job.hzy  = tzy;
    job.hzz  = tzz;
    job.nzx  = wp.zx;
    job.nzy  = wp.zy;
    job.nzz  = wp.zz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      hx <= '0; hy <= '0; hz <= '0;
      tzx <= '0; tzy <= '0; tzz <= '0;
    end else if (acc) begin
      if (wp.seg_end) begin
        held_valid <= 1'b0;
        hx <= '0; hy <= '0; hz <= '0;
        tzx <= '0; tzy <= '0; tzz <= '0;
      end else begin
        held_valid <= 1'b1;
        hx <= wp.px; hy <= wp.py; hz <= wp.pz;
        tzx <= wp.zx; tzy <= wp.zy; tzz <= wp.zz;
      end
    end
  end
endmodule

// ===== src/tdfa_queue.sv =====
// two-entry job queue between front and back
module tdfa_queue import tdfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);
  job_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_max: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count overflow");
  a_empty_rd: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd0 |-> !rd) else $error("read from empty queue");
  a_full_wr: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !wr) else $error("write to full queue");
`endif
endmodule

// ===== src/tdfa_back.sv =====
// back end: normalize step, two cross products per result
module tdfa_back import tdfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] ox_x, ox_y, ox_z, oy_x, oy_y, oy_z,
  output logic out_last
);
  localparam logic [3:0] S_IDLE = 4'd0, S_MAG = 4'd1, S_SCALE = 4'd2,
    S_SQ = 4'd3, S_SQRT = 4'd4, S_DIV = 4'd5, S_Y = 4'd6, S_X = 4'd7,
    S_OUT = 4'd8;

  logic [3:0] state;
  job_t       j;
  logic       second;
  logic [33:0] mag [3];
  logic        neg [3];
  logic [5:0]  blen;
  logic [20:0] e [3];
  logic [43:0] ssum;
  logic [43:0] srem;
  logic [21:0] root;
  logic [5:0]  cnt;
  logic [1:0]  idx;
  logic [36:0] drem;
  logic [15:0] dq;
  logic signed [15:0] dir [3];
  logic signed [15:0] ya [3];
  logic signed [15:0] za [3];

  // sqrt step (restoring, two bits a cycle)
  logic [43:0] sq_trial;
  logic [45:0] sq_rem2;
  // division step (one quotient bit a cycle)
  logic [36:0] d_trial;

  logic [33:0] m01, mmax;
  logic [5:0]  bl;
  logic [33:0] ev [3];

  always_comb begin
    m01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mmax = (m01 > mag[2]) ? m01 : mag[2];
    bl = '0;
    for (int k = 0; k < 34; k++) if (mmax[k]) bl = 6'(k + 1);
    for (int k = 0; k < 3; k++)
      ev[k] = (blen > 6'd20) ? (mag[k] >> (blen - 6'd20)) : (mag[k] << (6'd20 - blen));
  end

  assign sq_rem2  = {srem, 2'b00};
  assign sq_trial = 44'({root, 2'b01});
  assign d_trial  = {drem[35:0], 1'b0};

  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // numerator 2*e*2^14 + r, 37 bits, fed one bit a cycle msb first
  logic [36:0] num;
  logic        nb;
  logic signed [15:0] qfin;
  assign num  = {1'b0, e[idx], 15'd0} + 37'(root);
  assign nb   = num[6'd36 - cnt];
  assign qfin = {dq[14:0], ({d_trial[36:1], nb} >= {14'd0, root, 1'b0})};

  // cross products, rows formed combinationally from narrow factors
  logic signed [35:0] c [3];
  logic signed [15:0] a0, a1, a2, b0, b1, b2;
  always_comb begin
    if (state == S_Y) begin
      a0 = za[0]; a1 = za[1]; a2 = za[2];
      b0 = dir[0]; b1 = dir[1]; b2 = dir[2];
    end else begin
      a0 = ya[0]; a1 = ya[1]; a2 = ya[2];
      b0 = za[0]; b1 = za[1]; b2 = za[2];
    end
    c[0] = 36'(a1) * 36'(b2) - 36'(a2) * 36'(b1);
    c[1] = 36'(a2) * 36'(b0) - 36'(a0) * 36'(b2);
    c[2] = 36'(a0) * 36'(b1) - 36'(a1) * 36'(b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      second <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (job_valid) begin
          j <= job;
          second <= 1'b0;
          za[0] <= job.hzx; za[1] <= job.hzy; za[2] <= job.hzz;
          state <= S_MAG;
        end
        S_MAG: begin
          mag[0] <= j.dx[33] ? 34'(-j.dx) : j.dx;
          mag[1] <= j.dy[33] ? 34'(-j.dy) : j.dy;
          mag[2] <= j.dz[33] ? 34'(-j.dz) : j.dz;
          neg[0] <= j.dx[33]; neg[1] <= j.dy[33]; neg[2] <= j.dz[33];
          state <= S_SCALE;
        end
        S_SCALE: begin
          blen <= bl;
          if (bl == 6'd0 || j.kind == JOB_SINGLE) begin
            dir[0] <= '0; dir[1] <= '0; dir[2] <= '0;
            if (j.kind == JOB_SINGLE) begin
              ox_x <= '0; ox_y <= '0; ox_z <= '0;
              oy_x <= '0; oy_y <= '0; oy_z <= '0;
              out_last <= 1'b1;
              second <= 1'b1;
              state <= S_OUT;
            end else state <= S_Y;
          end else state <= S_SQ;
        end
        S_SQ: begin
          for (int k = 0; k < 3; k++) e[k] <= ev[k][20:0];
          ssum <= 44'(ev[0][20:0]) * 44'(ev[0][20:0]) + 44'(ev[1][20:0]) * 44'(ev[1][20:0])
                + 44'(ev[2][20:0]) * 44'(ev[2][20:0]);
          srem <= '0; root <= '0; cnt <= 6'd0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if ({sq_rem2[43:2], ssum[43:42]} >= sq_trial) begin
            srem <= {sq_rem2[43:2], ssum[43:42]} - sq_trial;
            root <= {root[20:0], 1'b1};
          end else begin
            srem <= {sq_rem2[43:2], ssum[43:42]};
            root <= {root[20:0], 1'b0};
          end
          ssum <= {ssum[41:0], 2'b00};
          if (cnt == 6'd21) begin
            cnt <= 6'd0; idx <= 2'd0; drem <= '0; dq <= '0;
            state <= S_DIV;
          end else cnt <= cnt + 6'd1;
        end
        S_DIV: begin
          // quotient of (2*e*2^14 + r) / (2r), bit serial over 16 bits
          // numerator bits fed msb first from a 37 bit value
          if (cnt == 6'd36) begin
            dir[idx] <= neg[idx] ? -qfin : qfin;
            cnt <= 6'd0; drem <= '0; dq <= '0;
            if (idx == 2'd2) state <= S_Y;
            else idx <= idx + 2'd1;
          end else begin
            if ({d_trial[36:1], nb} >= {14'd0, root, 1'b0}) begin
              drem <= {d_trial[36:1], nb} - {14'd0, root, 1'b0};
              dq <= {dq[14:0], 1'b1};
            end else begin
              drem <= {d_trial[36:1], nb};
              dq <= {dq[14:0], 1'b0};
            end
            cnt <= cnt + 6'd1;
          end
        end
        S_Y: begin
          for (int k = 0; k < 3; k++) ya[k] <= rsat14(c[k]);
          state <= S_X;
        end
        S_X: begin
          ox_x <= rsat14(c[0]); ox_y <= rsat14(c[1]); ox_z <= rsat14(c[2]);
          oy_x <= ya[0]; oy_y <= ya[1]; oy_z <= ya[2];
          out_last <= second;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          if (!second && j.two) begin
            second <= 1'b1;
            za[0] <= j.nzx; za[1] <= j.nzy; za[2] <= j.nzz;
            state <= S_Y;
          end else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ox_x) && $stable(oy_z))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !job_ready) else $error("job taken while busy");
  a_root: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> root != '0) else $error("zero root in divide");
`endif
endmodule

// ===== src/travel_direction_frame_align.sv =====
// Travel direction frame aligner top level. Waypoints enter through a front end that holds the
// previous waypoint and forms the exact position step; jobs pass a two-entry queue to a back end
// that block-scales the step, takes a 22-step bit-pair square root, divides each component bit
// serially, then forms y = z x dir and x = y x z one cross product per cycle.
// The time for an interior waypoint is set mostly by the square root and the three serial
// divides; the last waypoint of a segment adds a second pass through the cross products plus the
// output handshake for its second result. A lone last waypoint yields zero axes with no divides.
module travel_direction_frame_align import tdfa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] tool_z_x,
  input  logic signed [15:0] tool_z_y,
  input  logic signed [15:0] tool_z_z,
  input  logic segment_end,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] new_x_x,
  output logic signed [15:0] new_x_y,
  output logic signed [15:0] new_x_z,
  output logic signed [15:0] new_y_x,
  output logic signed [15:0] new_y_y,
  output logic signed [15:0] new_y_z,
  output logic last_of_segment
);
  wp_t  wp;
  job_t fjob, bjob;
  logic fvalid, fready, bvalid, bready;

  // waypoint bundle for the front end
  assign wp = '{px: pos_x, py: pos_y, pz: pos_z, zx: tool_z_x, zy: tool_z_y,
                zz: tool_z_z, seg_end: segment_end};

  tdfa_front u_front (
    .clk, .rst, .in_valid, .in_ready, .wp,
    .job_valid(fvalid), .job_ready(fready), .job(fjob)
  );

  tdfa_queue u_queue (
    .clk, .rst, .wr_valid(fvalid), .wr_ready(fready), .wr_data(fjob),
    .rd_valid(bvalid), .rd_ready(bready), .rd_data(bjob)
  );

  tdfa_back u_back (
    .clk, .rst, .job_valid(bvalid), .job_ready(bready), .job(bjob),
    .out_valid, .out_ready,
    .ox_x(new_x_x), .ox_y(new_x_y), .ox_z(new_x_z),
    .oy_x(new_y_x), .oy_y(new_y_y), .oy_z(new_y_z),
    .out_last(last_of_segment)
  );
endmodule

// ===== tb/travel_direction_frame_align_tb.sv =====
// self-checking testbench for the travel direction frame aligner
`timescale 1ns / 100ps

module travel_direction_frame_align_tb;
  import tdfa_pkg::*;

  // one frame as it leaves the block
  typedef struct packed {
    logic signed [15:0] xx;
    logic signed [15:0] xy;
    logic signed [15:0] xz;
    logic signed [15:0] yx;
    logic signed [15:0] yy;
    logic signed [15:0] yz;
    logic               last;
  } frame_t;

  // directed row: a waypoint and, where obvious, the frame it must give
  typedef struct packed {
    wp_t    wp;
    logic   typed;
    frame_t frame;
  } row_t;

  localparam int RANDOM_ITEMS = 1830;
  localparam logic [15:0] ONE = 16'sd16384;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic signed [15:0] tool_z_x, tool_z_y, tool_z_z;
  logic segment_end;
  logic signed [15:0] new_x_x, new_x_y, new_x_z, new_y_x, new_y_y, new_y_z;
  logic last_of_segment;

  travel_direction_frame_align DUT (.*);

  // predictor state: the waypoint waiting for its successor
  logic signed [31:0] hold_pos [3];
  logic signed [15:0] hold_z [3];
  logic               hold_ok;

  frame_t pending_frames [$];
  int     mismatches, frames_seen, waypoints_sent, segments_sent;
  bit     quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // generous fixed limit, far beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("timeout with %0d frames still pending", pending_frames.size());
    $display("FAILURE");
    $finish;
  end

  function automatic longint unsigned int_sqrt(input longint unsigned s);
    longint unsigned res, bitv;
    begin
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (s >= res + bitv) begin
          s = s - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      int_sqrt = res;
    end
  endfunction

  // q4.28 to q2.14, round half up, saturate
  function automatic longint round_q14(input longint v);
    longint q;
    begin
      q = (v + 8192) >>> 14;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      round_q14 = q;
    end
  endfunction

  // unit travel direction from the exact step, after block scaling to 20 bits
  task automatic unit_step(input longint d [3], output longint dir [3]);
    longint unsigned mag [3];
    longint unsigned m, s, r, num;
    int b;
    begin
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = (d[i] < 0) ? -d[i] : d[i];
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        for (int i = 0; i < 3; i++) dir[i] = 0;
      end else begin
        b = 0;
        while (b < 63 && (m >> b) != 0) b++;
        for (int i = 0; i < 3; i++) begin
          mag[i] = (b > 20) ? (mag[i] >> (b - 20)) : (mag[i] << (20 - b));
          s = s + mag[i] * mag[i];
        end
        r = int_sqrt(s);
        for (int i = 0; i < 3; i++) begin
          num = mag[i] * 16384;
          dir[i] = (2 * num + r) / (2 * r);
          if (d[i] < 0) dir[i] = -dir[i];
        end
      end
    end
  endtask

  task automatic cross_q14(input longint a [3], input longint c [3], output longint o [3]);
    begin
      o[0] = round_q14(a[1] * c[2] - a[2] * c[1]);
      o[1] = round_q14(a[2] * c[0] - a[0] * c[2]);
      o[2] = round_q14(a[0] * c[1] - a[1] * c[0]);
    end
  endtask

  // y = z x dir, then x = y x z with the rounded y
  task automatic build_frame(input longint z [3], input longint dir [3], input logic last,
                             output frame_t f);
    longint y [3];
    longint x [3];
    begin
      cross_q14(z, dir, y);
      cross_q14(y, z, x);
      f = {x[0][15:0], x[1][15:0], x[2][15:0], y[0][15:0], y[1][15:0], y[2][15:0], last};
    end
  endtask

  // advance the predictor by one waypoint and queue the frames it causes
  task automatic predict_frames(input wp_t w, input logic typed, input frame_t tframe);
    longint d [3];
    longint dir [3];
    longint hz [3];
    longint nz [3];
    longint np [3];
    frame_t f;
    begin
      np[0] = w.px; np[1] = w.py; np[2] = w.pz;
      nz[0] = w.zx; nz[1] = w.zy; nz[2] = w.zz;
      if (!hold_ok) begin
        if (w.seg_end) begin
          // lone last waypoint: zero axes
          f = '0;
          f.last = 1'b1;
          pending_frames.push_back(typed ? tframe : f);
        end else begin
          for (int i = 0; i < 3; i++) begin
            hold_pos[i] = np[i];
            hold_z[i] = nz[i];
          end
          hold_ok = 1'b1;
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          d[i] = np[i] - longint'(hold_pos[i]);
          hz[i] = hold_z[i];
        end
        unit_step(d, dir);
        build_frame(hz, dir, 1'b0, f);
        pending_frames.push_back(typed ? tframe : f);
        if (w.seg_end) begin
          // last waypoint reuses the direction of its predecessor
          build_frame(nz, dir, 1'b1, f);
          pending_frames.push_back(f);
          for (int i = 0; i < 3; i++) begin
            hold_pos[i] = '0;
            hold_z[i] = '0;
          end
          hold_ok = 1'b0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            hold_pos[i] = np[i];
            hold_z[i] = nz[i];
          end
        end
      end
    end
  endtask

  // present one transaction and hold it until accepted
  task automatic send_waypoint(input wp_t w, input logic typed, input frame_t tframe);
    begin
      predict_frames(w, typed, tframe);
      while (!quiet && $urandom_range(99) < 18) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      {pos_x, pos_y, pos_z, tool_z_x, tool_z_y, tool_z_z, segment_end} <= w;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      waypoints_sent++;
      if (w.seg_end) segments_sent++;
    end
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(3))
      0: rand_axis = 16'($urandom);
      1: rand_axis = 16'($urandom_range(32767) - 16384);
      2: rand_axis = $urandom_range(1) ? ONE : -ONE;
      default: rand_axis = '0;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_delta();
    case ($urandom_range(5))
      0: rand_delta = '0;
      1: rand_delta = 32'($urandom_range(15)) - 8;
      2: rand_delta = 32'($urandom_range(131072)) - 65536;
      3: rand_delta = 32'($urandom_range(1 << 24)) - (1 << 23);
      default: rand_delta = $urandom;
    endcase
  endfunction

  // output side: random back-pressure and checking against the oldest expectation
  always @(posedge clk) begin
    frame_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {new_x_x, new_x_y, new_x_z, new_y_x, new_y_y, new_y_z, last_of_segment};
        frames_seen++;
        if (pending_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected frame %h", got);
        end else begin
          want = pending_frames.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("frame %0d mismatch: expected x=%0d,%0d,%0d y=%0d,%0d,%0d last=%0d",
                       frames_seen, want.xx, want.xy, want.xz, want.yx, want.yy, want.yz,
                       want.last, "  actual x=%0d,%0d,%0d y=%0d,%0d,%0d last=%0d",
                       got.xx, got.xy, got.xz, got.yx, got.yy, got.yz, got.last);
          end
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 18);
    end
  end

  initial begin
    row_t   rows [$];
    row_t   r;
    wp_t    w;
    frame_t zf;
    logic signed [31:0] cur [3];
    int     seg_len, n, wait_cycles;

    rst = 1'b1;
    in_valid = 1'b0;
    {pos_x, pos_y, pos_z, tool_z_x, tool_z_y, tool_z_z, segment_end} = '0;
    hold_ok = 1'b0;
    for (int i = 0; i < 3; i++) begin
      hold_pos[i] = '0;
      hold_z[i] = '0;
    end
    mismatches = 0;
    frames_seen = 0;
    waypoints_sent = 0;
    segments_sent = 0;
    quiet = 1'b0;

    // directed table
    zf = '0;
    // lone last waypoint right after reset gives zero axes
    r = '{wp: '{32'sd5, 32'sd6, 32'sd7, ONE, 16'sd0, 16'sd0, 1'b1}, typed: 1'b1,
          frame: {96'd0, 1'b1}};
    rows.push_back(r);
    r = '{wp: '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, ONE, 1'b0}, typed: 1'b0, frame: zf};
    rows.push_back(r);
    // zero-length step gives zero axes
    r = '{wp: '{32'sd0, 32'sd0, 32'sd0, 16'sd0, ONE, 16'sd0, 1'b0}, typed: 1'b1, frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sd65536, 32'sd0, 32'sd0, 16'sd0, 16'sd0, ONE, 1'b0}, typed: 1'b0, frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 16'sh8000, 16'sh8000, 16'sh8000,
                1'b0}, typed: 1'b0, frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sh80000000, 32'sh80000000, 32'sh80000000, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                1'b0}, typed: 1'b0, frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sh80000001, 32'sh80000000, 32'sh7fffffff, 16'sh7fff, 16'sh8000, 16'sd0,
                1'b0}, typed: 1'b0, frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sh80000001, 32'sh80000000, 32'sh7fffffff, -ONE, 16'sd0, 16'sd0, 1'b1},
          typed: 1'b1, frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sd0, 32'sd0, 32'sd0, ONE, 16'sd0, 16'sd0, 1'b0}, typed: 1'b0, frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sd0, 32'sd0, 32'sd1, ONE, 16'sd0, 16'sd0, 1'b0}, typed: 1'b0, frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sd3, -32'sd4, 32'sd1, 16'sd0, -ONE, 16'sd0, 1'b0}, typed: 1'b0, frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sd3, -32'sd4, 32'sd1, 16'sd11585, 16'sd11585, 16'sd0, 1'b1},
          typed: 1'b0, frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}, typed: 1'b1,
          frame: {96'd0, 1'b1}};
    rows.push_back(r);
    r = '{wp: '{32'sh12345678, -32'sd1, 32'sd0, 16'sd0, 16'sd0, -ONE, 1'b0}, typed: 1'b0,
          frame: zf};
    rows.push_back(r);
    r = '{wp: '{32'sh12345679, -32'sd1, 32'sd0, 16'sd0, 16'sd0, -ONE, 1'b1}, typed: 1'b0,
          frame: zf};
    rows.push_back(r);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[k]) send_waypoint(rows[k].wp, rows[k].typed, rows[k].frame);

    // random segments: mostly random walks, with raw noise and lone endings mixed in
    n = 0;
    while (n < RANDOM_ITEMS) begin
      quiet = (n >= 700 && n < 1000);
      seg_len = ($urandom_range(9) == 0) ? 1 : $urandom_range(12, 2);
      cur[0] = $urandom;
      cur[1] = $urandom;
      cur[2] = $urandom;
      for (int j = 0; j < seg_len; j++) begin
        if ($urandom_range(9) == 0) begin
          w = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom),
               1'b0};
        end else begin
          cur[0] = cur[0] + rand_delta();
          cur[1] = cur[1] + rand_delta();
          cur[2] = cur[2] + rand_delta();
          w = '{cur[0], cur[1], cur[2], rand_axis(), rand_axis(), rand_axis(), 1'b0};
        end
        w.seg_end = (j == seg_len - 1);
        send_waypoint(w, 1'b0, zf);
        n++;
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    // drain, then allow for a frame still in flight
    while (pending_frames.size() != 0) @(posedge clk);
    wait_cycles = 300;
    repeat (wait_cycles) @(posedge clk);

    $display("sent %0d waypoints in %0d segments, checked %0d frames, %0d mismatches",
             waypoints_sent, segments_sent, frames_seen, mismatches);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
